// ===== rtl/cfp_pkg.sv =====
package cfp_pkg;

  localparam logic [7:0]  SYNC_BYTE  = 8'hFF;
  localparam logic [7:0]  LEN_SHORT  = 8'h03;
  localparam logic [7:0]  LEN_LONG   = 8'h06;
  localparam logic [7:0]  BODY_HDR   = 8'h01;
  localparam logic [7:0]  DEV_HOLDER = 8'h00;
  localparam logic [7:0]  DEV_LASER  = 8'h01;
  localparam logic [7:0]  OP_START   = 8'h00;
  localparam logic [7:0]  OP_STOP    = 8'h01;
  localparam logic [7:0]  OP_CHECK   = 8'hEE;
  localparam logic [7:0]  OP_ROTATE  = 8'h03;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  typedef enum logic [1:0] {
    ST_SHORT = 2'd0,
    ST_LONG  = 2'd1,
    ST_ERR   = 2'd2
  } frame_status_e;

  typedef enum logic [2:0] {
    CMD_HOLDER_START = 3'd0,
    CMD_HOLDER_STOP  = 3'd1,
    CMD_HOLDER_CHECK = 3'd2,
    CMD_LASER_START  = 3'd3,
    CMD_LASER_STOP   = 3'd4,
    CMD_LASER_CHECK  = 3'd5,
    CMD_DATA_ERR     = 3'd6
  } command_e;

  // one finished or rejected frame, handed from parser to decoder
  typedef struct packed {
    frame_status_e   status;
    logic [7:0]      device;
    logic [7:0]      opcode;
    logic [2:0][7:0] param;
  } frame_rec_t;

  // reflected CRC-16 step, init FFFF, polynomial A001, one byte per call
  function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = {8'h00, crc[15:8]} ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [6:0] bcd_value(logic [7:0] b);
    logic [6:0] v;
    if (b[7:4] > 4'd9 || b[3:0] > 4'd9) begin
      v = 7'd0;
    end else begin
      v = 7'(b[7:4]) * 7'd10 + 7'(b[3:0]);
    end
    return v;
  endfunction

endpackage

// ===== rtl/cfp_front.sv =====
module cfp_front import cfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       acc_i,
  input  logic [7:0] rx_byte_i,
  output logic       push_o,
  output frame_rec_t rec_o
);

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN  = 3'd1,
    PH_BODY = 3'd2,
    PH_CRCH = 3'd3,
    PH_CRCL = 3'd4
  } phase_e;

  phase_e          phase_q, phase_d;
  logic            long_q, long_d;
  logic [2:0]      idx_q, idx_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      dev_q, dev_d;
  logic [7:0]      op_q, op_d;
  logic [2:0][7:0] par_q, par_d;
  logic [7:0]      crch_q, crch_d;
  logic            crc_ok;

  assign crc_ok = (crch_q == crc_q[15:8]) && (rx_byte_i == crc_q[7:0]);

  always_comb begin
    phase_d = phase_q;
    long_d  = long_q;
    idx_d   = idx_q;
    crc_d   = crc_q;
    dev_d   = dev_q;
    op_d    = op_q;
    par_d   = par_q;
    crch_d  = crch_q;
    push_o  = 1'b0;
    rec_o   = '{status: ST_ERR, device: dev_q, opcode: op_q, param: par_q};
    if (acc_i) begin
      case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == SYNC_BYTE) begin
            phase_d = PH_LEN;
            crc_d   = CRC_INIT;
          end
        end
        PH_LEN: begin
          if (rx_byte_i == LEN_SHORT || rx_byte_i == LEN_LONG) begin
            long_d  = (rx_byte_i == LEN_LONG);
            idx_d   = 3'd0;
            dev_d   = 8'h00;
            op_d    = 8'h00;
            par_d   = '0;
            phase_d = PH_BODY;
          end else begin
            push_o  = 1'b1;
            phase_d = PH_HUNT;
          end
        end
        PH_BODY: begin
          if (idx_q == 3'd0 && rx_byte_i != BODY_HDR) begin
            push_o  = 1'b1;
            phase_d = PH_HUNT;
          end else begin
            case (idx_q)
              3'd1:    dev_d    = rx_byte_i;
              3'd2:    op_d     = rx_byte_i;
              3'd3:    par_d[0] = rx_byte_i;
              3'd4:    par_d[1] = rx_byte_i;
              3'd5:    par_d[2] = rx_byte_i;
              default: ;
            endcase
            crc_d = crc_update(crc_q, rx_byte_i);
            idx_d = idx_q + 3'd1;
            if (idx_q == (long_q ? 3'd5 : 3'd2)) begin
              phase_d = PH_CRCH;
            end
          end
        end
        PH_CRCH: begin
          crch_d  = rx_byte_i;
          phase_d = PH_CRCL;
        end
        PH_CRCL: begin
          push_o  = 1'b1;
          phase_d = PH_HUNT;
          if (crc_ok) begin
            rec_o.status = long_q ? ST_LONG : ST_SHORT;
          end
        end
        default: phase_d = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      long_q  <= 1'b0;
      idx_q   <= 3'd0;
    end else begin
      phase_q <= phase_d;
      long_q  <= long_d;
      idx_q   <= idx_d;
    end
  end

  // payload only: no reset; an error record may carry fields not yet loaded
  always_ff @(posedge clk_i) begin
    crc_q  <= crc_d;
    dev_q  <= dev_d;
    op_q   <= op_d;
    par_q  <= par_d;
    crch_q <= crch_d;
  end

  a_good_only_at_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && rec_o.status != ST_ERR |-> phase_q == PH_CRCL)
    else $error("good frame reported outside CRC check");

  a_no_push_hunting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> phase_q != PH_HUNT)
    else $error("request pushed while hunting for sync");

endmodule

// ===== rtl/cfp_queue.sv =====
module cfp_queue import cfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_i,
  input  frame_rec_t wr_data_i,
  input  logic       rd_i,
  output frame_rec_t rd_data_o,
  output logic       full_o,
  output logic       empty_o
);

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  frame_rec_t      mem_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [CntW-1:0] cnt_q;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i) begin
        wp_q <= (wp_q == PtrW'(Depth - 1)) ? '0 : wp_q + PtrW'(1);
      end
      if (rd_i) begin
        rp_q <= (rp_q == PtrW'(Depth - 1)) ? '0 : rp_q + PtrW'(1);
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> !full_o)
    else $error("frame queue written while full");

endmodule

// ===== rtl/cfp_back.sv =====
module cfp_back import cfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  frame_rec_t q_data_i,
  output logic       q_rd_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] frame_status_o,
  output logic [2:0] command_code_o,
  output logic [6:0] rotate_direction_o,
  output logic [6:0] rotate_speed_o,
  output logic [6:0] rotate_angle_o
);

  logic          valid_q;
  frame_status_e status_q;
  command_e      cmd_q, cmd_d;
  logic [6:0]    dir_q, spd_q, ang_q;
  logic          rotate;

  assign q_rd_o = !q_empty_i && (!valid_q || !out_stall_i);
  assign rotate = (q_data_i.status == ST_LONG) && (q_data_i.device == DEV_HOLDER)
                  && (q_data_i.opcode == OP_ROTATE);

  always_comb begin
    cmd_d = CMD_DATA_ERR;
    if (q_data_i.status != ST_ERR) begin
      if (q_data_i.device == DEV_HOLDER) begin
        case (q_data_i.opcode)
          OP_START: cmd_d = CMD_HOLDER_START;
          OP_STOP:  cmd_d = CMD_HOLDER_STOP;
          OP_CHECK: cmd_d = CMD_HOLDER_CHECK;
          default:  cmd_d = CMD_DATA_ERR;
        endcase
      end else if (q_data_i.device == DEV_LASER) begin
        case (q_data_i.opcode)
          OP_START: cmd_d = CMD_LASER_START;
          OP_STOP:  cmd_d = CMD_LASER_STOP;
          OP_CHECK: cmd_d = CMD_LASER_CHECK;
          default:  cmd_d = CMD_DATA_ERR;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_rd_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      status_q <= q_data_i.status;
      cmd_q    <= cmd_d;
      dir_q    <= rotate ? bcd_value(q_data_i.param[0]) : 7'd0;
      spd_q    <= rotate ? bcd_value(q_data_i.param[1]) : 7'd0;
      ang_q    <= rotate ? bcd_value(q_data_i.param[2]) : 7'd0;
    end
  end

  assign out_valid_o        = valid_q;
  assign frame_status_o     = status_q;
  assign command_code_o     = cmd_q;
  assign rotate_direction_o = dir_q;
  assign rotate_speed_o     = spd_q;
  assign rotate_angle_o     = ang_q;

  a_error_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && status_q == ST_ERR |->
      cmd_q == CMD_DATA_ERR && dir_q == 7'd0 && spd_q == 7'd0 && ang_q == 7'd0)
    else $error("error request carries command or rotate data");

endmodule

// ===== rtl/command_frame_parser.sv =====
// channel  | valid       | stall       | payload
// ---------+-------------+-------------+-----------------------------------------------
// rx in    | in_valid_i  | in_stall_o  | rx_byte_i
// frame out| out_valid_o | out_stall_i | frame_status_o, command_code_o, rotate_*_o
//
// One byte accepted per cycle while the frame queue is not full; the CRC update is a byte-wide step.
// After its last byte, a frame result is registered in the frame queue, then in the output register.
// in_stall_o rises only when the two-entry frame queue is full.
// Reset puts the parser in sync hunt with queue and output empty.
module command_frame_parser import cfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] frame_status_o,
  output logic [2:0] command_code_o,
  output logic [6:0] rotate_direction_o,
  output logic [6:0] rotate_speed_o,
  output logic [6:0] rotate_angle_o
);

  logic       acc, push, q_rd, q_full, q_empty;
  frame_rec_t rec, q_data;

  assign in_stall_o = q_full;
  assign acc        = in_valid_i && !q_full;

  cfp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .rx_byte_i (rx_byte_i),
    .push_o    (push),
    .rec_o     (rec)
  );

  cfp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (push),
    .wr_data_i (rec),
    .rd_i      (q_rd),
    .rd_data_o (q_data),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  cfp_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_empty_i          (q_empty),
    .q_data_i           (q_data),
    .q_rd_o             (q_rd),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .frame_status_o     (frame_status_o),
    .command_code_o     (command_code_o),
    .rotate_direction_o (rotate_direction_o),
    .rotate_speed_o     (rotate_speed_o),
    .rotate_angle_o     (rotate_angle_o)
  );

endmodule

// ===== tb/tb_command_frame_parser.sv =====
`timescale 1ns / 1ps

module tb_command_frame_parser;
  import cfp_pkg::*;

  localparam int CYCLE_LIMIT  = 100000;
  localparam int HOLDOFF_AT   = 300;
  localparam int HOLDOFF_LEN  = 200;
  localparam int QUIET_FROM   = 600;
  localparam int QUIET_TO     = 900;
  localparam int BYTE_TARGET  = 950;
  localparam int SETTLE_TICKS = 20;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN,
    PH_BODY,
    PH_CRC_HI,
    PH_CRC_LO
  } rx_phase_e;

  typedef struct packed {
    frame_status_e status;
    command_e      cmd;
    logic [6:0]    dir;
    logic [6:0]    speed;
    logic [6:0]    angle;
  } frame_result_t;

  // drain marks a point where the sender waits for all frame results
  typedef struct packed {
    bit         drain;
    logic [7:0] data;
  } rx_request_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] rx_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [1:0] frame_status_o;
  logic [2:0] command_code_o;
  logic [6:0] rotate_direction_o;
  logic [6:0] rotate_speed_o;
  logic [6:0] rotate_angle_o;

  rx_request_t   rx_requests_q[$];
  frame_result_t frame_results_q[$];
  rx_request_t   next_req;
  frame_result_t exp_frame;
  frame_result_t act_frame;
  bit            emits;
  int            results_owed = 0;
  int            cycle_cnt = 0;
  int            err_cnt = 0;
  int            bytes_queued = 0;
  int            holdoff_left = 0;
  bit            draining = 1'b0;
  bit            feed_done = 1'b0;
  wire           quiet = (cycle_cnt >= QUIET_FROM) && (cycle_cnt < QUIET_TO);

  // parser shadow state
  rx_phase_e   rx_phase = PH_HUNT;
  bit          is_long = 1'b0;
  logic [2:0]  bytes_left = '0;
  logic [15:0] crc_acc = 16'hFFFF;
  logic [7:0]  dev_byte = '0;
  logic [7:0]  op_byte = '0;
  logic [7:0]  param_b [3] = '{default: 8'h00};
  logic [7:0]  crc_hi_rx = '0;

  command_frame_parser u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .rx_byte_i          (rx_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .frame_status_o     (frame_status_o),
    .command_code_o     (command_code_o),
    .rotate_direction_o (rotate_direction_o),
    .rotate_speed_o     (rotate_speed_o),
    .rotate_angle_o     (rotate_angle_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [15:0] crc16_next(logic [15:0] acc, logic [7:0] d);
    logic [15:0] r;
    r = (acc >> 8) ^ {8'h00, d};
    repeat (8) r = (r >> 1) ^ (r[0] ? CRC_POLY : 16'h0000);
    return r;
  endfunction

  function automatic logic [6:0] bcd_to_bin(logic [7:0] v);
    if (v[7:4] > 4'd9 || v[3:0] > 4'd9) return 7'd0;
    return 7'(v[7:4]) * 7'd10 + 7'(v[3:0]);
  endfunction

  function automatic command_e decode_cmd(logic [7:0] dev, logic [7:0] op);
    logic [2:0] base;
    command_e   c;
    c = CMD_DATA_ERR;
    if (dev == DEV_HOLDER || dev == DEV_LASER) begin
      base = (dev == DEV_LASER) ? 3'(CMD_LASER_START) : 3'(CMD_HOLDER_START);
      case (op)
        OP_START: c = command_e'(base);
        OP_STOP:  c = command_e'(base + 3'd1);
        OP_CHECK: c = command_e'(base + 3'd2);
        default:  c = CMD_DATA_ERR;
      endcase
    end
    return c;
  endfunction

  task automatic parse_byte(input logic [7:0] b, output bit got, output frame_result_t r);
    int unsigned pos;
    got = 1'b0;
    r.status = ST_ERR;
    r.cmd    = CMD_DATA_ERR;
    r.dir    = '0;
    r.speed  = '0;
    r.angle  = '0;
    case (rx_phase)
      PH_HUNT: begin
        if (b == SYNC_BYTE) begin
          rx_phase = PH_LEN;
          crc_acc  = CRC_INIT;
        end
      end
      PH_LEN: begin
        if (b == LEN_SHORT || b == LEN_LONG) begin
          is_long    = (b == LEN_LONG);
          bytes_left = is_long ? 3'd6 : 3'd3;
          dev_byte   = '0;
          op_byte    = '0;
          param_b    = '{default: 8'h00};
          rx_phase   = PH_BODY;
        end else begin
          // rejected length byte is dropped, even a sync value
          got      = 1'b1;
          rx_phase = PH_HUNT;
        end
      end
      PH_BODY: begin
        pos = (is_long ? 6 : 3) - bytes_left;
        if (pos == 0 && b != BODY_HDR) begin
          got      = 1'b1;
          rx_phase = PH_HUNT;
        end else begin
          if (pos == 1) dev_byte = b;
          else if (pos == 2) op_byte = b;
          else if (pos >= 3 && pos <= 5) param_b[pos - 3] = b;
          crc_acc    = crc16_next(crc_acc, b);
          bytes_left = bytes_left - 3'd1;
          if (bytes_left == 0) rx_phase = PH_CRC_HI;
        end
      end
      PH_CRC_HI: begin
        crc_hi_rx = b;
        rx_phase  = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        rx_phase = PH_HUNT;
        got      = 1'b1;
        if (crc_hi_rx == crc_acc[15:8] && b == crc_acc[7:0]) begin
          r.status = is_long ? ST_LONG : ST_SHORT;
          r.cmd    = decode_cmd(dev_byte, op_byte);
          if (is_long && dev_byte == DEV_HOLDER && op_byte == OP_ROTATE) begin
            r.dir   = bcd_to_bin(param_b[0]);
            r.speed = bcd_to_bin(param_b[1]);
            r.angle = bcd_to_bin(param_b[2]);
          end
        end
      end
      default: rx_phase = PH_HUNT;
    endcase
  endtask

  task automatic push_byte(logic [7:0] b);
    rx_requests_q.push_back('{drain: 1'b0, data: b});
    bytes_queued++;
  endtask

  task automatic push_drain();
    rx_requests_q.push_back('{drain: 1'b1, data: 8'h00});
  endtask

  task automatic add_frame(bit long_f, logic [7:0] dev, logic [7:0] op,
                           logic [7:0] p0, logic [7:0] p1, logic [7:0] p2, bit bad_crc);
    logic [7:0]  body [6];
    logic [15:0] crc;
    int          n;
    body = '{BODY_HDR, dev, op, p0, p1, p2};
    n    = long_f ? 6 : 3;
    crc  = CRC_INIT;
    push_byte(SYNC_BYTE);
    push_byte(long_f ? LEN_LONG : LEN_SHORT);
    for (int i = 0; i < n; i++) begin
      push_byte(body[i]);
      crc = crc16_next(crc, body[i]);
    end
    if (bad_crc) crc ^= 16'(1) << $urandom_range(15);
    push_byte(crc[15:8]);
    push_byte(crc[7:0]);
  endtask

  function automatic logic [7:0] rand_param();
    if ($urandom_range(3) != 0) return {4'($urandom_range(9)), 4'($urandom_range(9))};
    return 8'($urandom);
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      rx_byte_i  <= 8'h00;
      draining   <= 1'b0;
      feed_done  <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (draining) begin
        in_valid_i <= 1'b0;
        if (results_owed == 0) draining <= 1'b0;
      end else if (rx_requests_q.size() == 0) begin
        in_valid_i <= 1'b0;
        feed_done  <= 1'b1;
      end else if (rx_requests_q[0].drain) begin
        void'(rx_requests_q.pop_front());
        in_valid_i <= 1'b0;
        draining   <= 1'b1;
      end else if (!quiet && $urandom_range(99) < 16) begin
        in_valid_i <= 1'b0;
      end else begin
        next_req   = rx_requests_q.pop_front();
        in_valid_i <= 1'b1;
        rx_byte_i  <= next_req.data;
      end
    end
  end

  // receiver, with one long hold-off so the frame queue fills and blocks input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i  <= 1'b0;
      holdoff_left <= 0;
    end else if (cycle_cnt == HOLDOFF_AT) begin
      out_stall_i  <= 1'b1;
      holdoff_left <= HOLDOFF_LEN;
    end else if (holdoff_left != 0) begin
      out_stall_i  <= (holdoff_left > 1);
      holdoff_left <= holdoff_left - 1;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(99) < 16);
    end
  end

  // predict on accepted bytes, check accepted frame results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_phase     = PH_HUNT;
      is_long      = 1'b0;
      bytes_left   = '0;
      crc_acc      = CRC_INIT;
      dev_byte     = '0;
      op_byte      = '0;
      param_b      = '{default: 8'h00};
      crc_hi_rx    = '0;
      results_owed <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        parse_byte(rx_byte_i, emits, exp_frame);
        if (emits) frame_results_q.push_back(exp_frame);
      end
      if (out_valid_o && !out_stall_i) begin
        act_frame.status = frame_status_e'(frame_status_o);
        act_frame.cmd    = command_e'(command_code_o);
        act_frame.dir    = rotate_direction_o;
        act_frame.speed  = rotate_speed_o;
        act_frame.angle  = rotate_angle_o;
        if (frame_results_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: unexpected frame result: status %0d cmd %0d dir %0d speed %0d angle %0d",
                     $time, frame_status_o, command_code_o, rotate_direction_o,
                     rotate_speed_o, rotate_angle_o);
        end else begin
          exp_frame = frame_results_q.pop_front();
          if (act_frame.status !== exp_frame.status || act_frame.cmd !== exp_frame.cmd ||
              act_frame.dir !== exp_frame.dir || act_frame.speed !== exp_frame.speed ||
              act_frame.angle !== exp_frame.angle) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%0t: mismatch exp status %0d cmd %0d rot %0d/%0d/%0d, got %0d %0d %0d/%0d/%0d",
                       $time, exp_frame.status, exp_frame.cmd, exp_frame.dir, exp_frame.speed,
                       exp_frame.angle, frame_status_o, command_code_o, rotate_direction_o,
                       rotate_speed_o, rotate_angle_o);
          end
        end
      end
      results_owed <= frame_results_q.size();
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int         kind;
    bit         long_f;
    bit         mid_drain_done;
    logic [7:0] b;
    logic [7:0] dev;
    logic [7:0] op;
    mid_drain_done = 1'b0;

    // noise while hunting, bad length incl. a second sync, bad header byte
    push_byte(8'h00);
    push_byte(SYNC_BYTE);
    push_byte(SYNC_BYTE);
    push_byte(SYNC_BYTE);
    push_byte(8'h00);
    push_byte(SYNC_BYTE);
    push_byte(LEN_SHORT);
    push_byte(8'hFF);
    add_frame(1'b0, DEV_HOLDER, OP_START, 8'h00, 8'h00, 8'h00, 1'b0);
    // rotate with BCD extremes and an invalid digit
    add_frame(1'b1, DEV_HOLDER, OP_ROTATE, 8'h99, 8'h00, 8'h9A, 1'b0);
    add_frame(1'b0, DEV_LASER, OP_CHECK, 8'h00, 8'h00, 8'h00, 1'b1);
    push_drain();

    while (bytes_queued < BYTE_TARGET) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        long_f = $urandom_range(1);
        case ($urandom_range(2))
          0:       dev = DEV_HOLDER;
          1:       dev = DEV_LASER;
          default: dev = 8'($urandom);
        endcase
        case ($urandom_range(4))
          0:       op = OP_START;
          1:       op = OP_STOP;
          2:       op = OP_CHECK;
          3:       op = OP_ROTATE;
          default: op = 8'($urandom);
        endcase
        if (long_f && $urandom_range(9) < 4) begin
          dev = DEV_HOLDER;
          op  = OP_ROTATE;
        end
        add_frame(long_f, dev, op, rand_param(), rand_param(), rand_param(),
                  $urandom_range(9) == 0);
      end else if (kind < 78) begin
        b = 8'($urandom);
        while (b == LEN_SHORT || b == LEN_LONG) b = 8'($urandom);
        push_byte(SYNC_BYTE);
        push_byte(b);
      end else if (kind < 86) begin
        b = 8'($urandom);
        while (b == BODY_HDR) b = 8'($urandom);
        push_byte(SYNC_BYTE);
        push_byte($urandom_range(1) ? LEN_LONG : LEN_SHORT);
        push_byte(b);
      end else begin
        repeat ($urandom_range(1, 5)) push_byte(8'($urandom));
      end
      if (!mid_drain_done && bytes_queued > BYTE_TARGET / 2) begin
        push_drain();
        mid_drain_done = 1'b1;
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!feed_done) @(posedge clk_i);
    while (results_owed != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);

    if (err_cnt == 0 && frame_results_q.size() == 0) begin
      $display("PASS");
    end else begin
      if (frame_results_q.size() != 0)
        $display("%0d frame results never arrived", frame_results_q.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule
